@@ src/sipl_pkg.sv @@
// ----------------------------------------------------------------------------
// sipl_pkg
// shared types and constants of the sorted insertion priority list
// ----------------------------------------------------------------------------
package sipl_pkg;

  localparam int unsigned DEF_CAPACITY = 32;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_W      = 6;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DUMP   = 1'b1;

  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // place the broadcast value
    logic rot;  // rotate the occupied cells one place toward the head
  } sipl_cell_ctl_t;

endpackage

@@ src/sorted_insert_priority_list_core.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_priority_list_core
// stable descending sorted list built from a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// input word: action_i (insert or dump) and value_i, taken when in_valid_i is
// high and in_stall_o is low. output word: kind_o, accepted_o, count_o,
// entry_value_o and last_o, taken when out_valid_o is high and out_stall_i
// is low.
// an insert into a list that is not full is placed by all cells at once in
// the cycle it is taken; its acknowledgement shows on the output in the next
// cycle. inserts are taken one per cycle while the output side keeps up.
// a dump of n values rotates the chain one place toward the head per cycle
// while the output side keeps up; the head value goes out, and after n
// rotations the list is back in order. the input is stalled for the whole
// dump. an empty dump gives no word.
// when the receiver stalls, the output register holds its word and the input
// side stalls too.
// reset empties the list and the output register; cell contents are not
// cleared, since only occupied cells are ever read.
// ----------------------------------------------------------------------------
module sorted_insert_priority_list_core #(
  parameter int unsigned CAPACITY = sipl_pkg::DEF_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic signed [sipl_pkg::VALUE_W-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                kind_o,
  output logic                                accepted_o,
  output logic [sipl_pkg::COUNT_W-1:0]        count_o,
  output logic signed [sipl_pkg::VALUE_W-1:0] entry_value_o,
  output logic                                last_o
);
  import sipl_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic {
    StIdle,
    StDump
  } state_e;

  state_e                    state_q;
  logic [CntW-1:0]           count_q;
  logic [CntW-1:0]           rem_q;
  logic                      out_valid_q;
  logic                      kind_q;
  logic                      accepted_q;
  logic [COUNT_W-1:0]        out_count_q;
  logic signed [VALUE_W-1:0] entry_value_q;
  logic                      last_q;

  sipl_cell_ctl_t            ctl;
  logic                      out_load;
  logic                      out_fill;
  logic                      in_take;
  logic                      full;
  logic [CntW-1:0]           count_inc;

  logic                      ge     [CAPACITY];
  logic signed [VALUE_W-1:0] cell_v [CAPACITY];

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == StDump) || !out_load;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_fill   = (state_q == StDump) || (in_take && (action_i == ACT_INSERT));
  assign full       = (count_q == CntW'(CAPACITY));
  assign count_inc  = count_q + CntW'(1);

  always_comb begin
    ctl.ins = in_take && (action_i == ACT_INSERT) && !full;
    ctl.rot = (state_q == StDump) && out_load;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      valid;
    logic                      prev_ge;
    logic signed [VALUE_W-1:0] prev_v;
    logic signed [VALUE_W-1:0] next_v;

    assign valid = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_ge = 1'b1;
      assign prev_v  = value_i;
    end else begin : g_mid
      assign prev_ge = ge[i-1];
      assign prev_v  = cell_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign next_v = cell_v[i];
    end else begin : g_nxt
      assign next_v = cell_v[i+1];
    end

    sipl_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .valid_i      (valid),
      .is_tail_i    (CntW'(i + 1) == count_q),
      .ins_value_i  (value_i),
      .prev_ge_i    (prev_ge),
      .prev_value_i (prev_v),
      .next_value_i (next_v),
      .head_value_i (cell_v[0]),
      .ge_o         (ge[i]),
      .value_o      (cell_v[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      count_q       <= '0;
      rem_q         <= '0;
      out_valid_q   <= 1'b0;
      kind_q        <= KIND_ACK;
      accepted_q    <= 1'b0;
      out_count_q   <= '0;
      entry_value_q <= '0;
      last_q        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= out_fill;
      end
      case (state_q)
        StIdle: begin
          if (in_take) begin
            if (action_i == ACT_INSERT) begin
              kind_q        <= KIND_ACK;
              accepted_q    <= !full;
              out_count_q   <= full ? COUNT_W'(count_q) : COUNT_W'(count_inc);
              entry_value_q <= '0;
              last_q        <= 1'b1;
              if (!full) begin
                count_q <= count_inc;
              end
            end else if (count_q != '0) begin
              state_q <= StDump;
              rem_q   <= count_q;
            end
          end
        end
        StDump: begin
          if (out_load) begin
            kind_q        <= KIND_ENTRY;
            accepted_q    <= 1'b0;
            out_count_q   <= COUNT_W'(count_q);
            entry_value_q <= cell_v[0];
            last_q        <= (rem_q == CntW'(1));
            rem_q         <= rem_q - CntW'(1);
            if (rem_q == CntW'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign accepted_o    = accepted_q;
  assign count_o       = out_count_q;
  assign entry_value_o = entry_value_q;
  assign last_o        = last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("count above capacity");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_ACK) |-> last_q)
    else $error("acknowledgement without last");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ins |=> count_q == $past(count_inc))
    else $error("count not advanced by insert");

  a_dump_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDump) |-> in_stall_o && !ctl.ins)
    else $error("input taken during dump");

endmodule

@@ src/sipl_cell.sv @@
// ----------------------------------------------------------------------------
// sipl_cell
// one slot of the sorted chain: compare, hold, or take the inserted value, a neighbor's value or the head value
// ----------------------------------------------------------------------------
module sipl_cell (
  input  logic                                clk_i,
  input  sipl_pkg::sipl_cell_ctl_t            ctl_i,
  input  logic                                valid_i,
  input  logic                                is_tail_i,
  input  logic signed [sipl_pkg::VALUE_W-1:0] ins_value_i,
  input  logic                                prev_ge_i,
  input  logic signed [sipl_pkg::VALUE_W-1:0] prev_value_i,
  input  logic signed [sipl_pkg::VALUE_W-1:0] next_value_i,
  input  logic signed [sipl_pkg::VALUE_W-1:0] head_value_i,
  output logic                                ge_o,
  output logic signed [sipl_pkg::VALUE_W-1:0] value_o
);
  import sipl_pkg::*;

  logic signed [VALUE_W-1:0] value_q;
  logic signed [VALUE_W-1:0] value_d;

  assign ge_o    = valid_i && (value_q >= ins_value_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctl_i.ins) begin
      if (!ge_o) begin
        value_d = prev_ge_i ? ins_value_i : prev_value_i;
      end
    end else if (ctl_i.rot) begin
      if (is_tail_i) begin
        value_d = head_value_i;
      end else if (valid_i) begin
        value_d = next_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule
